@@ rtl/hcr_pkg.sv @@
// hcr_pkg: shared constants, word types, controller commands and status
// for the harris corner response block; no dependencies
`timescale 1ns / 1ps

package hcr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W    = 11;
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 10;
    localparam int RESP_W   = 32;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int RC_W     = $clog2(MAX_HEIGHT + 1);
    localparam int POS_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int ADDR_W   = COL_W + 2;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int GRAD_W   = 11;
    localparam int GMEM_W   = 2 * GRAD_W;
    localparam int ACC_W    = 26;
    localparam int PROD_W   = 2 * ACC_W;
    localparam int FRAC_W   = 8;
    localparam int DIVD_W   = PROD_W + FRAC_W;
    localparam int REM_W    = ACC_W + 1;
    localparam int DCNT_W   = $clog2(DIVD_W + 1);
    localparam int WIN_N    = 9;
    localparam int IDX_W    = $clog2(WIN_N + 1);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } pixel_word_t;

    typedef struct packed {
        logic [RESP_W-1:0]  response;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_last;
    } result_word_t;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_GRAD_SCAN,
        ST_GRAD_WRITE,
        ST_RESP_SCAN,
        ST_MUL_A,
        ST_MUL_B,
        ST_CHECK,
        ST_DIV,
        ST_OUT_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic decide;
        logic scan_clear;
        logic scan_run;
        logic scan_resp;
        logic grad_write;
        logic mul_a;
        logic mul_b;
        logic div_load;
        logic div_run;
        logic out_load;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic grad_do;
        logic out_do;
        logic scan_done;
        logic div_done;
        logic out_free;
    } status_t;

    // window offsets, raster order over the 3x3 neighbourhood
    function automatic logic signed [1:0] win_dr(input logic [IDX_W-1:0] idx);
        logic signed [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = -2'sd1;
            4'd3, 4'd4, 4'd5: r = 2'sd0;
            default:          r = 2'sd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] win_dc(input logic [IDX_W-1:0] idx);
        logic signed [1:0] c;
        case (idx)
            4'd0, 4'd3, 4'd6: c = -2'sd1;
            4'd1, 4'd4, 4'd7: c = 2'sd0;
            default:          c = 2'sd1;
        endcase
        return c;
    endfunction

    // sobel weights: gx is right minus left, gy is below minus above
    function automatic logic signed [2:0] sobel_wx(input logic [IDX_W-1:0] idx);
        logic signed [2:0] k;
        case (idx)
            4'd0, 4'd6: k = -3'sd1;
            4'd2, 4'd8: k = 3'sd1;
            4'd3:       k = -3'sd2;
            4'd5:       k = 3'sd2;
            default:    k = 3'sd0;
        endcase
        return k;
    endfunction

    function automatic logic signed [2:0] sobel_wy(input logic [IDX_W-1:0] idx);
        logic signed [2:0] k;
        case (idx)
            4'd0, 4'd2: k = -3'sd1;
            4'd6, 4'd8: k = 3'sd1;
            4'd1:       k = -3'sd2;
            4'd7:       k = 3'sd2;
            default:    k = 3'sd0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/harris_corner_response_core.sv @@
// harris_corner_response_core: top level of the harris corner response block
// depends on hcr_pkg, hcr_ctrl, hcr_datapath (and hcr_ram below it)
`timescale 1ns / 1ps

// gray pixels come in one word at a time in raster order; each result word
// carries det/trace of the 3x3 structure tensor of one pixel (sobel
// gradients, zero padding, 8 fraction bits), its row and column, and a
// frame_last flag. results trail the input by two rows plus two pixels, so
// 2*width+2 flush words drain a frame. words are handled one at a time; a
// flush word within the frame is ignored, and the time a word takes is set
// by the nine tap window reads through the single read port of each line
// store, the 60 step restoring divider (skipped when det or trace is not
// positive) and any wait of its result on a stalled output. a register
// write restarts the frame and belongs only between words, with nothing
// in flight.

module harris_corner_response_core
    import hcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  pixel_word_t      pixel_word,
    output logic             result_valid,
    input  logic             result_stall,
    output result_word_t     result_word,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t st;

    hcr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .st          (st),
        .cmd         (cmd)
    );

    hcr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .pixel_word   (pixel_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

`ifndef SYNTH
    // a result word appears only after the sequencer loads it
    a_rise_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.out_load))
        else $error("result word raised without a load");

    // a load always leaves a valid result word
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result_valid)
        else $error("result word lost after load");

    // the decide step follows an accepted input word
    a_decide_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> $past(pixel_valid && !pixel_stall))
        else $error("decide without an accepted word");
`endif

endmodule

@@ rtl/hcr_ram.sv @@
// hcr_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module hcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hcr_ctrl.sv @@
// hcr_ctrl: sequencing state machine for one word at a time
// depends on hcr_pkg
`timescale 1ns / 1ps

module hcr_ctrl
    import hcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (st.skip)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.grad_do)
                begin
                    state_next = ST_GRAD_SCAN;
                end
                else if (st.out_do)
                begin
                    state_next = ST_RESP_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_GRAD_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = ST_GRAD_WRITE;
                end
            end
            ST_GRAD_WRITE:
            begin
                state_next = st.out_do ? ST_RESP_SCAN : ST_FINISH;
            end
            ST_RESP_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        pixel_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:       cmd.take = pixel_valid;
            ST_DECIDE:
            begin
                cmd.decide     = 1'b1;
                cmd.scan_clear = 1'b1;
            end
            ST_GRAD_SCAN:  cmd.scan_run = 1'b1;
            ST_GRAD_WRITE:
            begin
                cmd.grad_write = 1'b1;
                cmd.scan_clear = 1'b1;
            end
            ST_RESP_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_resp = 1'b1;
            end
            ST_MUL_A:      cmd.mul_a = 1'b1;
            ST_MUL_B:      cmd.mul_b = 1'b1;
            ST_CHECK:      cmd.div_load = 1'b1;
            ST_DIV:        cmd.div_run = 1'b1;
            ST_OUT_WAIT:   cmd.out_load = st.out_free;
            ST_FINISH:     cmd.finish = 1'b1;
            default:       cmd = '0;
        endcase
    end

endmodule

@@ rtl/hcr_datapath.sv @@
// hcr_datapath: positions, line stores, window scans, tensor and divider
// depends on hcr_pkg and hcr_ram
`timescale 1ns / 1ps

module hcr_datapath
    import hcr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output status_t      st,
    input  pixel_word_t  pixel_word,
    input  logic         cfg_we,
    input  cfg_index_t   cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result_word
);

    // configuration and positions
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0] total_reg;
    logic [POS_W-1:0] t_reg, kpos_reg;
    logic [1:0]       in_row_reg;
    logic [COL_W-1:0] in_col_reg, g_col_reg, k_col_reg;
    logic [RC_W-1:0]  g_row_reg, k_row_reg;
    logic [COL_W-1:0] w_m1;
    logic             in_frame, last_res;

    pixel_word_t item_reg;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    assign w_m1     = COL_W'(w_eff - DIM_W'(1));
    assign in_frame = (t_reg < total_reg);
    assign last_res = ((kpos_reg + POS_W'(1)) == total_reg);

    logic [POS_W:0] t_ext, w1_ext, w2_ext;
    assign t_ext  = {1'b0, t_reg};
    assign w1_ext = (POS_W+1)'(w_eff) + (POS_W+1)'(1);
    assign w2_ext = w1_ext + w1_ext;

    assign st.skip    = in_frame && item_reg.flush;
    assign st.grad_do = (t_ext >= w1_ext) && ((t_ext - w1_ext) < {1'b0, total_reg});
    assign st.out_do  = (t_ext >= w2_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            total_reg  <= '0;
            t_reg      <= '0;
            kpos_reg   <= '0;
            in_row_reg <= '0;
            in_col_reg <= '0;
            g_row_reg  <= '0;
            g_col_reg  <= '0;
            k_row_reg  <= '0;
            k_col_reg  <= '0;
        end
        else
        begin
            total_reg <= POS_W'(w_eff) * POS_W'(h_eff);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
                t_reg      <= '0;
                kpos_reg   <= '0;
                in_row_reg <= '0;
                in_col_reg <= '0;
                g_row_reg  <= '0;
                g_col_reg  <= '0;
                k_row_reg  <= '0;
                k_col_reg  <= '0;
            end
            else if (cmd.finish)
            begin
                if (st.out_do && last_res)
                begin
                    t_reg      <= '0;
                    kpos_reg   <= '0;
                    in_row_reg <= '0;
                    in_col_reg <= '0;
                    g_row_reg  <= '0;
                    g_col_reg  <= '0;
                    k_row_reg  <= '0;
                    k_col_reg  <= '0;
                end
                else
                begin
                    t_reg <= t_reg + POS_W'(1);
                    if (in_col_reg == w_m1)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 2'd1;
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + COL_W'(1);
                    end
                    if (st.grad_do)
                    begin
                        if (g_col_reg == w_m1)
                        begin
                            g_col_reg <= '0;
                            g_row_reg <= g_row_reg + RC_W'(1);
                        end
                        else
                        begin
                            g_col_reg <= g_col_reg + COL_W'(1);
                        end
                    end
                    if (st.out_do)
                    begin
                        kpos_reg <= kpos_reg + POS_W'(1);
                        if (k_col_reg == w_m1)
                        begin
                            k_col_reg <= '0;
                            k_row_reg <= k_row_reg + RC_W'(1);
                        end
                        else
                        begin
                            k_col_reg <= k_col_reg + COL_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= pixel_word;
        end
    end

    // window scan: one tap address a cycle, registered ram read
    logic [IDX_W-1:0] idx_reg;
    logic             s1_valid_reg, s1_mask_reg, s2_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [RC_W-1:0]  ctr_row;
    logic [COL_W-1:0] ctr_col;
    int               tap_r, tap_c;
    logic             tap_mask;
    logic [ADDR_W-1:0] tap_addr;
    logic             issue;

    assign ctr_row  = cmd.scan_resp ? k_row_reg : g_row_reg;
    assign ctr_col  = cmd.scan_resp ? k_col_reg : g_col_reg;
    assign tap_r    = int'(ctr_row) + int'(win_dr(idx_reg));
    assign tap_c    = int'(ctr_col) + int'(win_dc(idx_reg));
    assign tap_mask = (tap_r >= 0) && (tap_r < int'(h_eff)) &&
                      (tap_c >= 0) && (tap_c < int'(w_eff));
    assign tap_addr = {2'(tap_r), COL_W'(tap_c)};
    assign issue    = cmd.scan_run && (int'(idx_reg) < WIN_N);

    assign st.scan_done = (int'(idx_reg) == WIN_N) && !s1_valid_reg && !s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg && cmd.scan_resp;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= idx_reg;
        s1_mask_reg <= tap_mask;
    end

    // line stores
    logic [PIX_W-1:0]  pix_wdata, pix_rdata;
    logic [GMEM_W-1:0] grad_rdata;
    logic [ADDR_W-1:0] pix_waddr, grad_waddr;
    logic              pix_we;

    assign pix_we     = cmd.decide && !st.skip;
    assign pix_wdata  = in_frame ? item_reg.pixel : '0;
    assign pix_waddr  = {in_row_reg, in_col_reg};
    assign grad_waddr = {g_row_reg[1:0], g_col_reg};

    logic signed [GRAD_W:0] gx_acc_reg, gy_acc_reg;

    hcr_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (tap_addr),
        .rdata (pix_rdata)
    );

    hcr_ram #(.WIDTH(GMEM_W), .DEPTH(RAM_DEPTH)) u_grad_ram (
        .clk   (clk),
        .we    (cmd.grad_write),
        .waddr (grad_waddr),
        .wdata ({gx_acc_reg[GRAD_W-1:0], gy_acc_reg[GRAD_W-1:0]}),
        .raddr (tap_addr),
        .rdata (grad_rdata)
    );

    // gradient accumulation
    logic signed [GRAD_W:0] pix_s, term_x, term_y;
    logic signed [2:0]      wx, wy;

    assign pix_s  = s1_mask_reg ? $signed({{(GRAD_W+1-PIX_W){1'b0}}, pix_rdata}) : '0;
    assign wx     = sobel_wx(s1_idx_reg);
    assign wy     = sobel_wy(s1_idx_reg);
    assign term_x = pix_s * wx;
    assign term_y = pix_s * wy;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_clear)
        begin
            gx_acc_reg <= '0;
            gy_acc_reg <= '0;
        end
        else if (s1_valid_reg && !cmd.scan_resp)
        begin
            gx_acc_reg <= gx_acc_reg + term_x;
            gy_acc_reg <= gy_acc_reg + term_y;
        end
    end

    // structure tensor accumulation
    logic signed [GRAD_W-1:0] rd_gx, rd_gy;
    logic signed [ACC_W-1:0]  pxx_reg, pxy_reg, pyy_reg;
    logic signed [ACC_W-1:0]  sxx_reg, sxy_reg, syy_reg;
    logic signed [ACC_W-1:0]  ext_gx, ext_gy;

    assign rd_gx  = grad_rdata[GMEM_W-1:GRAD_W];
    assign rd_gy  = grad_rdata[GRAD_W-1:0];
    assign ext_gx = ACC_W'(rd_gx);
    assign ext_gy = ACC_W'(rd_gy);

    always_ff @(posedge clk)
    begin
        if (s1_mask_reg)
        begin
            pxx_reg <= ACC_W'(ext_gx * ext_gx);
            pxy_reg <= ACC_W'(ext_gx * ext_gy);
            pyy_reg <= ACC_W'(ext_gy * ext_gy);
        end
        else
        begin
            pxx_reg <= '0;
            pxy_reg <= '0;
            pyy_reg <= '0;
        end
        if (cmd.scan_clear)
        begin
            sxx_reg <= '0;
            sxy_reg <= '0;
            syy_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            sxx_reg <= sxx_reg + pxx_reg;
            sxy_reg <= sxy_reg + pxy_reg;
            syy_reg <= syy_reg + pyy_reg;
        end
    end

    // shared multiplier for det
    logic signed [ACC_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod, p1_reg, p2_reg, det;
    logic signed [ACC_W-1:0]  trace;
    logic                     nonzero;

    assign op_a    = cmd.mul_b ? sxy_reg : sxx_reg;
    assign op_b    = cmd.mul_b ? sxy_reg : syy_reg;
    assign prod    = op_a * op_b;
    assign det     = p1_reg - p2_reg;
    assign trace   = sxx_reg + syy_reg;
    assign nonzero = (trace > 0) && (det > 0);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
        begin
            p1_reg <= prod;
        end
        if (cmd.mul_b)
        begin
            p2_reg <= prod;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [DIVD_W-1:0] quo_reg;
    logic [REM_W-1:0]  rem_reg, rem_shift;
    logic [ACC_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              fits;

    assign rem_shift   = {rem_reg[REM_W-2:0], quo_reg[DIVD_W-1]};
    assign fits        = (rem_shift >= {1'b0, dvs_reg});
    assign st.div_done = (dcnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            dcnt_reg <= nonzero ? DCNT_W'(DIVD_W) : '0;
        end
        else if (cmd.div_run && (dcnt_reg != '0))
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= nonzero ? {det, {FRAC_W{1'b0}}} : '0;
            rem_reg <= '0;
            dvs_reg <= trace;
        end
        else if (cmd.div_run && (dcnt_reg != '0))
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    // result register
    logic         result_valid_reg;
    result_word_t result_word_reg;

    assign st.out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_word_reg.response   <= quo_reg[RESP_W-1:0];
            result_word_reg.row        <= COORD_W'(k_row_reg);
            result_word_reg.col        <= COORD_W'(k_col_reg);
            result_word_reg.frame_last <= last_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

endmodule
